// ----- design/qfir_pkg.sv -----
package qfir_pkg;

    // Depth of the sample history and of each coefficient set.
    localparam int MAX_TAPS = 64;
    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int SMP_W    = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 6;
    localparam int TCNT_W   = 7;
    localparam int PROD_W   = SMP_W + COEF_W;
    localparam int ACC_W    = 38;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = ((SMP_W + IDX_W + COEF_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * ACC_W + 7) / 8) * 8;

    localparam logic [TCNT_W-1:0] TAP_COUNT_RST = TCNT_W'(MAX_TAPS);

    // Item kinds carried on the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_WR_I   = 2'd1,
        FUNC_WR_Q   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

// ----- design/quadrature_fir_filter.sv -----
// Each sample starts one pass over the tap memories with one read per tap, N = min(tap_count, 64);
// its result is registered into the output once the pipeline has drained, and an earlier result
// still waiting on the output delays it further. No new sample, tap write or history clear is
// accepted until that result has been placed in the output register.
// Reset (aresetn low, synchronous): history and both tap sets read as zero, the newest
// position returns to zero, tap_count returns to 64 and the output holds no result.
module quadrature_fir_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel: tap_count.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qfir_pkg::TCNT_W-1:0]         cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0 up: sample[15:0], tap_index[21:16], tap_value[37:22], zero pad.
    input  logic [qfir_pkg::S_DATA_W-1:0]       s_tdata,
    // tuser: func[1:0].
    input  logic [qfir_pkg::FUNC_W-1:0]         s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata from bit 0 up: i_out[37:0], q_out[75:38], zero pad.
    output logic [qfir_pkg::M_DATA_W-1:0]       m_tdata
);

    // Unpacked input fields.
    qfir_pkg::func_t                     in_func;
    logic signed [qfir_pkg::SMP_W-1:0]   in_sample;
    logic [qfir_pkg::IDX_W-1:0]          in_tap_index;
    logic signed [qfir_pkg::COEF_W-1:0]  in_tap_value;
    logic                                s_fire;

    assign in_func      = qfir_pkg::func_t'(s_tuser);
    assign in_sample    = s_tdata[qfir_pkg::SMP_W-1:0];
    assign in_tap_index = s_tdata[qfir_pkg::SMP_W +: qfir_pkg::IDX_W];
    assign in_tap_value = s_tdata[qfir_pkg::SMP_W + qfir_pkg::IDX_W +: qfir_pkg::COEF_W];
    assign s_fire       = s_tvalid && s_tready;

    // Control and datapath registers.
    qfir_pkg::state_t                    state_reg, state_next;
    logic [qfir_pkg::ADDR_W-1:0]         pos_reg, pos_next;
    logic [qfir_pkg::TCNT_W-1:0]         tap_count_reg;
    logic [qfir_pkg::CNT_W-1:0]          k_reg, k_next;
    logic [qfir_pkg::CNT_W-1:0]          n_eff;
    logic                                rd_vld_reg, rd_vld_next;
    logic                                mul_vld_reg;
    logic                                m_valid_reg, m_valid_next;
    logic signed [qfir_pkg::ACC_W-1:0]   acc_i_reg, acc_q_reg;
    logic signed [qfir_pkg::ACC_W-1:0]   m_i_reg, m_q_reg;
    logic signed [qfir_pkg::PROD_W-1:0]  prod_i_reg, prod_q_reg;

    // Entry valid bits: a clear entry reads as zero.
    logic [qfir_pkg::MAX_TAPS-1:0]       hist_vld_reg, icoef_vld_reg, qcoef_vld_reg;

    // Memories and their registered read ports.
    logic [qfir_pkg::SMP_W-1:0]          hist_mem  [qfir_pkg::MAX_TAPS];
    logic [qfir_pkg::COEF_W-1:0]         icoef_mem [qfir_pkg::MAX_TAPS];
    logic [qfir_pkg::COEF_W-1:0]         qcoef_mem [qfir_pkg::MAX_TAPS];
    logic [qfir_pkg::SMP_W-1:0]          hist_rd_reg;
    logic [qfir_pkg::COEF_W-1:0]         icoef_rd_reg, qcoef_rd_reg;
    logic                                hist_rv_reg, icoef_rv_reg, qcoef_rv_reg;

    logic [qfir_pkg::ADDR_W-1:0]         hist_raddr, coef_raddr;
    logic                                issue;
    logic                                out_free;
    logic                                wr_hist, wr_icoef, wr_qcoef;
    logic signed [qfir_pkg::SMP_W-1:0]   smp_eff;
    logic signed [qfir_pkg::COEF_W-1:0]  ci_eff, cq_eff;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == qfir_pkg::ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(qfir_pkg::M_DATA_W - 2 * qfir_pkg::ACC_W){1'b0}}, m_q_reg, m_i_reg};

    // Effective tap count, limited to the memory depth.
    always_comb begin
        if (tap_count_reg > qfir_pkg::TCNT_W'(qfir_pkg::MAX_TAPS)) begin
            n_eff = qfir_pkg::CNT_W'(qfir_pkg::MAX_TAPS);
        end else begin
            n_eff = qfir_pkg::CNT_W'(tap_count_reg);
        end
    end

    // Write strobes for the three memories.
    assign wr_hist  = s_fire && (in_func == qfir_pkg::FUNC_SAMPLE);
    assign wr_icoef = s_fire && (in_func == qfir_pkg::FUNC_WR_I);
    assign wr_qcoef = s_fire && (in_func == qfir_pkg::FUNC_WR_Q);

    // The newest sample goes one place below the previous one.
    assign pos_next = wr_hist ? (pos_reg - qfir_pkg::ADDR_W'(1)) : pos_reg;

    // Read addresses for tap k: history walks up from the newest sample.
    assign hist_raddr = pos_reg + k_reg[qfir_pkg::ADDR_W-1:0];
    assign coef_raddr = k_reg[qfir_pkg::ADDR_W-1:0];
    assign out_free   = !m_valid_reg || m_tready;

    // Sequencer: issue one tap read per cycle, then drain the pipeline.
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        issue        = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            qfir_pkg::ST_IDLE: begin
                if (wr_hist) begin
                    state_next = qfir_pkg::ST_RUN;
                    k_next     = '0;
                end
            end
            qfir_pkg::ST_RUN: begin
                if (k_reg == n_eff) begin
                    state_next = qfir_pkg::ST_DRAIN;
                end else begin
                    issue  = 1'b1;
                    k_next = k_reg + qfir_pkg::CNT_W'(1);
                end
            end
            qfir_pkg::ST_DRAIN: begin
                if (!rd_vld_reg && !mul_vld_reg && out_free) begin
                    state_next   = qfir_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = qfir_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_vld_next = issue;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qfir_pkg::ST_IDLE;
            pos_reg       <= '0;
            tap_count_reg <= qfir_pkg::TAP_COUNT_RST;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            k_reg       <= k_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= rd_vld_reg;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                tap_count_reg <= cfg_data;
            end
        end
    end

    // Valid bits: set on write, history bits cleared by a clear transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg  <= '0;
            icoef_vld_reg <= '0;
            qcoef_vld_reg <= '0;
        end else begin
            if (s_fire && (in_func == qfir_pkg::FUNC_CLEAR)) begin
                hist_vld_reg <= '0;
            end else if (wr_hist) begin
                hist_vld_reg[pos_next] <= 1'b1;
            end
            if (wr_icoef) begin
                icoef_vld_reg[in_tap_index] <= 1'b1;
            end
            if (wr_qcoef) begin
                qcoef_vld_reg[in_tap_index] <= 1'b1;
            end
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_hist) begin
            hist_mem[pos_next] <= in_sample;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
        hist_rv_reg <= hist_vld_reg[hist_raddr];
    end

    // In-phase coefficient memory.
    always_ff @(posedge aclk) begin
        if (wr_icoef) begin
            icoef_mem[in_tap_index] <= in_tap_value;
        end
        icoef_rd_reg <= icoef_mem[coef_raddr];
        icoef_rv_reg <= icoef_vld_reg[coef_raddr];
    end

    // Quadrature coefficient memory.
    always_ff @(posedge aclk) begin
        if (wr_qcoef) begin
            qcoef_mem[in_tap_index] <= in_tap_value;
        end
        qcoef_rd_reg <= qcoef_mem[coef_raddr];
        qcoef_rv_reg <= qcoef_vld_reg[coef_raddr];
    end

    // Entries never written since reset or clear read as zero.
    assign smp_eff = hist_rv_reg  ? $signed(hist_rd_reg)  : '0;
    assign ci_eff  = icoef_rv_reg ? $signed(icoef_rd_reg) : '0;
    assign cq_eff  = qcoef_rv_reg ? $signed(qcoef_rd_reg) : '0;

    // Multiply stage, then accumulate stage.
    always_ff @(posedge aclk) begin
        prod_i_reg <= ci_eff * smp_eff;
        prod_q_reg <= cq_eff * smp_eff;
        if (wr_hist) begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end else if (mul_vld_reg) begin
            acc_i_reg <= acc_i_reg + qfir_pkg::ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + qfir_pkg::ACC_W'(prod_q_reg);
        end
    end

    // Output register holds the finished sums until the transaction completes.
    always_ff @(posedge aclk) begin
        if ((state_reg == qfir_pkg::ST_DRAIN) && (state_next == qfir_pkg::ST_IDLE)) begin
            m_i_reg <= acc_i_reg;
            m_q_reg <= acc_q_reg;
        end
    end

endmodule
